FILE: rtl/tnf_pkg.sv
package tnf_pkg;

    localparam int MAX_BOXES_DEFAULT  = 64;
    localparam int COORD_BITS_DEFAULT = 12;

    localparam int SCORE_W  = 16;
    localparam int WEIGHT_W = 16;
    localparam int LIMIT_W  = 16;
    localparam int KEEP_W   = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int EXP_DEPTH  = 256;

    localparam logic [CFG_IDX_W-1:0] REG_OVERLAP_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MERGE_MODE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEEP_COUNT    = 2'd2;

    localparam logic [LIMIT_W-1:0] OVERLAP_LIMIT_RESET = 16'd19661;
    localparam logic [KEEP_W-1:0]  KEEP_COUNT_RESET    = 7'd64;

    typedef struct packed {
        logic [LIMIT_W-1:0] overlap_limit;
        logic               merge_mode;
        logic [KEEP_W-1:0]  keep_count;
    } cfg_t;

    typedef struct packed {
        logic valid;
        logic final_box;
    } queue_status_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SORT_I,
        ST_SORT_IW,
        ST_SORT_J,
        ST_SORT_JW,
        ST_NMS_CHK,
        ST_NMS_RANK,
        ST_NMS_LEAD,
        ST_NMS_LAREA,
        ST_ACC,
        ST_J_CHK,
        ST_J_RANK,
        ST_J_LOAD,
        ST_OV_MUL,
        ST_OV_UNI,
        ST_OV_TEST,
        ST_EMIT,
        ST_DIV_SET,
        ST_DIV_RUN,
        ST_DIV_END,
        ST_OUT,
        ST_FINISH
    } back_state_t;

    typedef logic [WEIGHT_W-1:0] exp_table_t [EXP_DEPTH];

    // exp(idx/256) in Q2.14 from a Taylor series through the twelfth power in Q30.
    function automatic logic [WEIGHT_W-1:0] exp_entry(input int unsigned idx);
        longint unsigned x;
        longint unsigned term;
        longint unsigned sum;
        x    = longint'(idx & 255) << 22;
        term = 64'd1 << 30;
        sum  = term;
        term = ((term * x) >> 30) / 1;  sum = sum + term;
        term = ((term * x) >> 30) / 2;  sum = sum + term;
        term = ((term * x) >> 30) / 3;  sum = sum + term;
        term = ((term * x) >> 30) / 4;  sum = sum + term;
        term = ((term * x) >> 30) / 5;  sum = sum + term;
        term = ((term * x) >> 30) / 6;  sum = sum + term;
        term = ((term * x) >> 30) / 7;  sum = sum + term;
        term = ((term * x) >> 30) / 8;  sum = sum + term;
        term = ((term * x) >> 30) / 9;  sum = sum + term;
        term = ((term * x) >> 30) / 10; sum = sum + term;
        term = ((term * x) >> 30) / 11; sum = sum + term;
        term = ((term * x) >> 30) / 12; sum = sum + term;
        sum = (sum + (64'd1 << 15)) >> 16;
        return sum[WEIGHT_W-1:0];
    endfunction

    function automatic exp_table_t build_exp_table();
        exp_table_t t;
        for (int i = 0; i < EXP_DEPTH; i++)
        begin
            t[i] = exp_entry(i);
        end
        return t;
    endfunction

    localparam exp_table_t EXP_TABLE = build_exp_table();

endpackage

FILE: rtl/topk_nms_box_filter.sv
// Top-k box filter with non-maximum suppression. Boxes of one set come in one
// item at a time and are stored; the item flagged final_box starts processing.
// Loading takes one cycle per box through a two-entry input queue while no set
// is being worked on. The set is then ranked by descending score, and
// suppression tests each free kept box against its cluster leader on a single
// box-memory read port, then accumulates the five weighted fields of each box
// that joins a cluster. In blend mode each cluster's fields go through a
// bit-serial divider of ACC_W bits, where ACC_W is 39 for 64 boxes. Results
// leave through a registered output with valid and ready, and new boxes queue
// up while the current set is being worked on.
module topk_nms_box_filter #(
    parameter int MAX_BOXES  = tnf_pkg::MAX_BOXES_DEFAULT,
    parameter int COORD_BITS = tnf_pkg::COORD_BITS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [tnf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tnf_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [COORD_BITS-1:0]          left_edge,
    input  logic [COORD_BITS-1:0]          top_edge,
    input  logic [COORD_BITS-1:0]          right_edge,
    input  logic [COORD_BITS-1:0]          bottom_edge,
    input  logic [tnf_pkg::SCORE_W-1:0]    confidence,
    input  logic                           final_box,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [COORD_BITS-1:0]          out_left,
    output logic [COORD_BITS-1:0]          out_top,
    output logic [COORD_BITS-1:0]          out_right,
    output logic [COORD_BITS-1:0]          out_bottom,
    output logic [tnf_pkg::SCORE_W-1:0]    out_confidence,
    output logic                           final_result
);

    localparam int ITEM_W = 4 * COORD_BITS + tnf_pkg::SCORE_W + 1;

    tnf_pkg::cfg_t          cfg_reg;
    tnf_pkg::queue_status_t q_status;
    logic [ITEM_W-1:0]      q_item;
    logic                   q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.overlap_limit <= tnf_pkg::OVERLAP_LIMIT_RESET;
            cfg_reg.merge_mode    <= 1'b0;
            cfg_reg.keep_count    <= tnf_pkg::KEEP_COUNT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                tnf_pkg::REG_OVERLAP_LIMIT: cfg_reg.overlap_limit <= cfg_data;
                tnf_pkg::REG_MERGE_MODE:    cfg_reg.merge_mode    <= cfg_data[0];
                tnf_pkg::REG_KEEP_COUNT:
                    cfg_reg.keep_count <= cfg_data[tnf_pkg::KEEP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    tnf_front #(
        .ITEM_W (ITEM_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   ({left_edge, top_edge, right_edge, bottom_edge, confidence, final_box}),
        .pop       (q_pop),
        .status    (q_status),
        .head_item (q_item)
    );

    tnf_back #(
        .MAX_BOXES  (MAX_BOXES),
        .COORD_BITS (COORD_BITS),
        .ITEM_W     (ITEM_W)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_status       (q_status),
        .q_item         (q_item),
        .q_pop          (q_pop),
        .cfg            (cfg_reg),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_left       (out_left),
        .out_top        (out_top),
        .out_right      (out_right),
        .out_bottom     (out_bottom),
        .out_confidence (out_confidence),
        .final_result   (final_result)
    );

endmodule

FILE: rtl/tnf_front.sv
module tnf_front #(
    parameter int ITEM_W = 65
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [ITEM_W-1:0]      in_item,
    input  logic                   pop,
    output tnf_pkg::queue_status_t status,
    output logic [ITEM_W-1:0]      head_item
);

    logic [ITEM_W-1:0] slot_reg [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        count_reg, count_next;
    logic              push;
    logic              take;

    assign in_ready  = (count_reg != 2'd2);
    assign push      = in_valid && in_ready;
    assign take      = pop && (count_reg != 2'd0);
    assign head_item = slot_reg[rd_ptr_reg];

    // The lowest bit of an item is its last-box flag.
    assign status.valid     = (count_reg != 2'd0);
    assign status.final_box = slot_reg[rd_ptr_reg][0];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = take ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

FILE: rtl/tnf_back.sv
module tnf_back #(
    parameter int MAX_BOXES  = tnf_pkg::MAX_BOXES_DEFAULT,
    parameter int COORD_BITS = tnf_pkg::COORD_BITS_DEFAULT,
    parameter int ITEM_W     = 4 * COORD_BITS + tnf_pkg::SCORE_W + 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tnf_pkg::queue_status_t      q_status,
    input  logic [ITEM_W-1:0]           q_item,
    output logic                        q_pop,
    input  tnf_pkg::cfg_t               cfg,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [COORD_BITS-1:0]       out_left,
    output logic [COORD_BITS-1:0]       out_top,
    output logic [COORD_BITS-1:0]       out_right,
    output logic [COORD_BITS-1:0]       out_bottom,
    output logic [tnf_pkg::SCORE_W-1:0] out_confidence,
    output logic                        final_result
);

    localparam int C      = COORD_BITS;
    localparam int SW     = tnf_pkg::SCORE_W;
    localparam int WW     = tnf_pkg::WEIGHT_W;
    localparam int IW     = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CW     = $clog2(MAX_BOXES + 1);
    localparam int BOX_W  = 4 * C;
    localparam int WORD_W = BOX_W + SW;
    localparam int DIM_W  = C + 2;
    localparam int AREA_W = 2 * DIM_W;
    localparam int UNI_W  = AREA_W + 2;
    localparam int PROD_W = tnf_pkg::LIMIT_W + UNI_W - 1;
    localparam int ACC_W  = SW + WW + IW + 1;
    localparam int WS_W   = WW + IW;
    localparam int DC_W   = $clog2(ACC_W);
    localparam int CMP_W  = tnf_pkg::KEEP_W + 1;

    tnf_pkg::back_state_t state_reg, state_next;

    // Box store, written in arrival order, and the rank list built by the sort.
    logic [WORD_W-1:0] box_mem [MAX_BOXES];
    logic [IW-1:0]     rank_mem [MAX_BOXES];
    logic [WORD_W-1:0] box_q_reg;
    logic [IW-1:0]     rank_q_reg;
    logic [IW-1:0]     box_raddr;
    logic [IW-1:0]     rank_raddr;
    logic              box_we;
    logic              rank_we;

    logic [CW-1:0]        loaded_reg, i_reg, j_reg, cnt_reg, kept_reg;
    logic [SW-1:0]        si_reg;
    logic [MAX_BOXES-1:0] absorbed_reg;
    logic [BOX_W-1:0]     lead_box_reg, cur_box_reg;
    logic [SW-1:0]        lead_score_reg, cur_score_reg;
    logic [WW-1:0]        cur_w_reg;
    logic signed [DIM_W-1:0]  ldw_reg, ldh_reg, iw_reg, ih_reg, ow_reg, oh_reg;
    logic signed [AREA_W-1:0] larea_reg, inter_reg, oarea_reg;
    logic signed [UNI_W-1:0]  uni_reg;
    logic                 nonempty_reg;
    logic [ACC_W-1:0]     acc_reg [5];
    logic [WS_W-1:0]      wsum_reg;
    logic [2:0]           f_reg;
    logic [ACC_W-1:0]     dvd_reg, quo_reg;
    logic [WS_W:0]        rem_reg;
    logic [DC_W-1:0]      dcnt_reg;
    logic [SW-1:0]        res_reg [5];
    logic                 out_valid_reg;
    logic [C-1:0]         out_left_reg, out_top_reg, out_right_reg, out_bottom_reg;
    logic [SW-1:0]        out_conf_reg;
    logic                 out_final_reg;

    logic [C-1:0]  mq_l, mq_t, mq_r, mq_b;
    logic [C-1:0]  cl_l, cl_t, cl_r, cl_b, cu_l, cu_t, cu_r, cu_b;
    logic [SW-1:0] mq_score;
    logic          store_ok;
    logic [SW-1:0] acc_field;
    logic [CW-1:0] kept_calc;
    logic          sort_before;
    logic          hit;
    logic [WS_W:0] rem_sh;
    logic          div_ge;
    logic [MAX_BOXES-1:0] pending;
    logic          out_free;

    assign mq_l     = box_q_reg[WORD_W-1 -: C];
    assign mq_t     = box_q_reg[WORD_W-1-C -: C];
    assign mq_r     = box_q_reg[WORD_W-1-2*C -: C];
    assign mq_b     = box_q_reg[WORD_W-1-3*C -: C];
    assign mq_score = box_q_reg[SW-1:0];

    assign cl_l = lead_box_reg[BOX_W-1 -: C];
    assign cl_t = lead_box_reg[BOX_W-1-C -: C];
    assign cl_r = lead_box_reg[2*C-1 -: C];
    assign cl_b = lead_box_reg[C-1:0];
    assign cu_l = cur_box_reg[BOX_W-1 -: C];
    assign cu_t = cur_box_reg[BOX_W-1-C -: C];
    assign cu_r = cur_box_reg[2*C-1 -: C];
    assign cu_b = cur_box_reg[C-1:0];

    assign store_ok = (loaded_reg < CW'(MAX_BOXES));
    assign out_free = !out_valid_reg || out_ready;

    assign kept_calc = (CMP_W'(cfg.keep_count) < CMP_W'(loaded_reg))
                       ? CW'(cfg.keep_count) : loaded_reg;

    // Stable order: an equal score loaded earlier ranks first.
    assign sort_before = (mq_score > si_reg) || ((mq_score == si_reg) && (j_reg < i_reg));

    assign hit = nonempty_reg && !uni_reg[UNI_W-1] && (uni_reg != '0) &&
                 (PROD_W'({inter_reg[AREA_W-2:0], 16'h0}) >
                  (PROD_W'(cfg.overlap_limit) * PROD_W'(uni_reg[UNI_W-2:0])));

    assign rem_sh = {rem_reg[WS_W-1:0], dvd_reg[ACC_W-1]};
    assign div_ge = (rem_sh >= {1'b0, wsum_reg});

    always_comb
    begin
        for (int k = 0; k < MAX_BOXES; k++)
        begin
            pending[k] = !absorbed_reg[k] && (CW'(k) > i_reg) && (CW'(k) < kept_reg);
        end
    end

    always_comb
    begin
        unique case (f_reg)
            3'd0:    acc_field = SW'(cu_l);
            3'd1:    acc_field = SW'(cu_t);
            3'd2:    acc_field = SW'(cu_r);
            3'd3:    acc_field = SW'(cu_b);
            default: acc_field = cur_score_reg;
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tnf_pkg::ST_IDLE:
                if (q_status.valid && q_status.final_box)
                    state_next = tnf_pkg::ST_SORT_I;
            tnf_pkg::ST_SORT_I:
                state_next = (i_reg >= loaded_reg) ? tnf_pkg::ST_NMS_CHK : tnf_pkg::ST_SORT_IW;
            tnf_pkg::ST_SORT_IW:
                state_next = tnf_pkg::ST_SORT_J;
            tnf_pkg::ST_SORT_J:
                state_next = (j_reg >= loaded_reg) ? tnf_pkg::ST_SORT_I : tnf_pkg::ST_SORT_JW;
            tnf_pkg::ST_SORT_JW:
                state_next = tnf_pkg::ST_SORT_J;
            tnf_pkg::ST_NMS_CHK:
                priority if (i_reg >= kept_reg)
                    state_next = tnf_pkg::ST_FINISH;
                else if (absorbed_reg[i_reg[IW-1:0]])
                    state_next = tnf_pkg::ST_NMS_CHK;
                else
                    state_next = tnf_pkg::ST_NMS_RANK;
            tnf_pkg::ST_NMS_RANK:
                state_next = tnf_pkg::ST_NMS_LEAD;
            tnf_pkg::ST_NMS_LEAD:
                state_next = tnf_pkg::ST_NMS_LAREA;
            tnf_pkg::ST_NMS_LAREA:
                state_next = tnf_pkg::ST_ACC;
            tnf_pkg::ST_ACC:
                if (f_reg == 3'd4)
                    state_next = tnf_pkg::ST_J_CHK;
            tnf_pkg::ST_J_CHK:
                priority if (j_reg >= kept_reg)
                    state_next = tnf_pkg::ST_EMIT;
                else if (absorbed_reg[j_reg[IW-1:0]])
                    state_next = tnf_pkg::ST_J_CHK;
                else
                    state_next = tnf_pkg::ST_J_RANK;
            tnf_pkg::ST_J_RANK:
                state_next = tnf_pkg::ST_J_LOAD;
            tnf_pkg::ST_J_LOAD:
                state_next = tnf_pkg::ST_OV_MUL;
            tnf_pkg::ST_OV_MUL:
                state_next = tnf_pkg::ST_OV_UNI;
            tnf_pkg::ST_OV_UNI:
                state_next = tnf_pkg::ST_OV_TEST;
            tnf_pkg::ST_OV_TEST:
                state_next = hit ? tnf_pkg::ST_ACC : tnf_pkg::ST_J_CHK;
            tnf_pkg::ST_EMIT:
                state_next = cfg.merge_mode ? tnf_pkg::ST_DIV_SET : tnf_pkg::ST_OUT;
            tnf_pkg::ST_DIV_SET:
                state_next = tnf_pkg::ST_DIV_RUN;
            tnf_pkg::ST_DIV_RUN:
                if (dcnt_reg == '0)
                    state_next = tnf_pkg::ST_DIV_END;
            tnf_pkg::ST_DIV_END:
                state_next = (f_reg == 3'd4) ? tnf_pkg::ST_OUT : tnf_pkg::ST_DIV_SET;
            tnf_pkg::ST_OUT:
                if (out_free)
                    state_next = tnf_pkg::ST_NMS_CHK;
            tnf_pkg::ST_FINISH:
                state_next = tnf_pkg::ST_IDLE;
            default:
                state_next = tnf_pkg::ST_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb
    begin
        q_pop      = 1'b0;
        box_we     = 1'b0;
        rank_we    = 1'b0;
        box_raddr  = i_reg[IW-1:0];
        rank_raddr = i_reg[IW-1:0];
        unique case (state_reg)
            tnf_pkg::ST_IDLE:
            begin
                q_pop  = q_status.valid;
                box_we = q_status.valid && store_ok;
            end
            tnf_pkg::ST_SORT_J:
            begin
                box_raddr = j_reg[IW-1:0];
                rank_we   = (j_reg >= loaded_reg);
            end
            tnf_pkg::ST_J_CHK:
                rank_raddr = j_reg[IW-1:0];
            tnf_pkg::ST_NMS_RANK, tnf_pkg::ST_J_RANK:
                box_raddr = rank_q_reg;
            default:
            begin
                box_raddr  = i_reg[IW-1:0];
                rank_raddr = i_reg[IW-1:0];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (box_we)
        begin
            box_mem[loaded_reg[IW-1:0]] <= q_item[ITEM_W-1:1];
        end
        if (rank_we)
        begin
            rank_mem[cnt_reg[IW-1:0]] <= i_reg[IW-1:0];
        end
        box_q_reg  <= box_mem[box_raddr];
        rank_q_reg <= rank_mem[rank_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tnf_pkg::ST_IDLE;
            loaded_reg    <= '0;
            absorbed_reg  <= '0;
            out_valid_reg <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            f_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;
            // A new result may replace the one taken in the same cycle.
            if (state_reg == tnf_pkg::ST_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                tnf_pkg::ST_IDLE:
                begin
                    i_reg <= '0;
                    if (box_we)
                    begin
                        loaded_reg <= loaded_reg + CW'(1);
                    end
                end
                tnf_pkg::ST_SORT_I:
                begin
                    if (i_reg >= loaded_reg)
                    begin
                        i_reg <= '0;
                    end
                end
                tnf_pkg::ST_SORT_IW:
                    j_reg <= '0;
                tnf_pkg::ST_SORT_J:
                begin
                    if (j_reg >= loaded_reg)
                    begin
                        i_reg <= i_reg + CW'(1);
                    end
                end
                tnf_pkg::ST_SORT_JW:
                    j_reg <= j_reg + CW'(1);
                tnf_pkg::ST_NMS_CHK:
                begin
                    if (i_reg < kept_reg && absorbed_reg[i_reg[IW-1:0]])
                    begin
                        i_reg <= i_reg + CW'(1);
                    end
                end
                tnf_pkg::ST_NMS_LEAD:
                begin
                    absorbed_reg[i_reg[IW-1:0]] <= 1'b1;
                    j_reg <= i_reg + CW'(1);
                    f_reg <= '0;
                end
                tnf_pkg::ST_ACC:
                    f_reg <= (f_reg == 3'd4) ? 3'd0 : f_reg + 3'd1;
                tnf_pkg::ST_J_CHK:
                begin
                    if (j_reg < kept_reg && absorbed_reg[j_reg[IW-1:0]])
                    begin
                        j_reg <= j_reg + CW'(1);
                    end
                end
                tnf_pkg::ST_OV_TEST:
                begin
                    if (hit)
                    begin
                        absorbed_reg[j_reg[IW-1:0]] <= 1'b1;
                    end
                    j_reg <= j_reg + CW'(1);
                    f_reg <= '0;
                end
                tnf_pkg::ST_EMIT:
                    f_reg <= '0;
                tnf_pkg::ST_DIV_END:
                    f_reg <= (f_reg == 3'd4) ? 3'd0 : f_reg + 3'd1;
                tnf_pkg::ST_OUT:
                begin
                    if (out_free)
                    begin
                        i_reg <= i_reg + CW'(1);
                    end
                end
                tnf_pkg::ST_FINISH:
                begin
                    loaded_reg   <= '0;
                    absorbed_reg <= '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Datapath registers, no reset needed.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            tnf_pkg::ST_SORT_I:
                kept_reg <= kept_calc;
            tnf_pkg::ST_SORT_IW:
            begin
                si_reg  <= mq_score;
                cnt_reg <= '0;
            end
            tnf_pkg::ST_SORT_JW:
            begin
                if (sort_before)
                begin
                    cnt_reg <= cnt_reg + CW'(1);
                end
            end
            tnf_pkg::ST_NMS_LEAD:
            begin
                lead_box_reg   <= box_q_reg[WORD_W-1:SW];
                lead_score_reg <= mq_score;
                cur_box_reg    <= box_q_reg[WORD_W-1:SW];
                cur_score_reg  <= mq_score;
                cur_w_reg      <= tnf_pkg::EXP_TABLE[mq_score[SW-1 -: 8]];
                ldw_reg  <= {2'b00, mq_r} - {2'b00, mq_l} + DIM_W'(1);
                ldh_reg  <= {2'b00, mq_b} - {2'b00, mq_t} + DIM_W'(1);
                wsum_reg <= '0;
                for (int r = 0; r < 5; r++)
                begin
                    acc_reg[r] <= '0;
                end
            end
            tnf_pkg::ST_NMS_LAREA:
                larea_reg <= ldw_reg * ldh_reg;
            tnf_pkg::ST_ACC:
            begin
                acc_reg[f_reg] <= acc_reg[f_reg] + ACC_W'(cur_w_reg * acc_field);
                if (f_reg == 3'd0)
                begin
                    wsum_reg <= wsum_reg + WS_W'(cur_w_reg);
                end
            end
            tnf_pkg::ST_J_LOAD:
            begin
                cur_box_reg   <= box_q_reg[WORD_W-1:SW];
                cur_score_reg <= mq_score;
                iw_reg <= {2'b00, ((mq_r < cl_r) ? mq_r : cl_r)}
                        - {2'b00, ((mq_l > cl_l) ? mq_l : cl_l)} + DIM_W'(1);
                ih_reg <= {2'b00, ((mq_b < cl_b) ? mq_b : cl_b)}
                        - {2'b00, ((mq_t > cl_t) ? mq_t : cl_t)} + DIM_W'(1);
                ow_reg <= {2'b00, mq_r} - {2'b00, mq_l} + DIM_W'(1);
                oh_reg <= {2'b00, mq_b} - {2'b00, mq_t} + DIM_W'(1);
            end
            tnf_pkg::ST_OV_MUL:
            begin
                inter_reg    <= iw_reg * ih_reg;
                oarea_reg    <= ow_reg * oh_reg;
                nonempty_reg <= !iw_reg[DIM_W-1] && (iw_reg != '0) &&
                                !ih_reg[DIM_W-1] && (ih_reg != '0);
            end
            tnf_pkg::ST_OV_UNI:
                uni_reg <= UNI_W'(larea_reg) + UNI_W'(oarea_reg) - UNI_W'(inter_reg);
            tnf_pkg::ST_OV_TEST:
                cur_w_reg <= tnf_pkg::EXP_TABLE[cur_score_reg[SW-1 -: 8]];
            tnf_pkg::ST_EMIT:
            begin
                res_reg[0] <= SW'(cl_l);
                res_reg[1] <= SW'(cl_t);
                res_reg[2] <= SW'(cl_r);
                res_reg[3] <= SW'(cl_b);
                res_reg[4] <= lead_score_reg;
            end
            tnf_pkg::ST_DIV_SET:
            begin
                // Adding half the weight sum rounds the quotient to nearest.
                dvd_reg  <= acc_reg[f_reg] + ACC_W'(wsum_reg >> 1);
                rem_reg  <= '0;
                quo_reg  <= '0;
                dcnt_reg <= DC_W'(ACC_W - 1);
            end
            tnf_pkg::ST_DIV_RUN:
            begin
                rem_reg  <= div_ge ? (rem_sh - {1'b0, wsum_reg}) : rem_sh;
                quo_reg  <= {quo_reg[ACC_W-2:0], div_ge};
                dvd_reg  <= {dvd_reg[ACC_W-2:0], 1'b0};
                dcnt_reg <= dcnt_reg - DC_W'(1);
            end
            tnf_pkg::ST_DIV_END:
                res_reg[f_reg] <= quo_reg[SW-1:0];
            tnf_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    out_left_reg   <= res_reg[0][C-1:0];
                    out_top_reg    <= res_reg[1][C-1:0];
                    out_right_reg  <= res_reg[2][C-1:0];
                    out_bottom_reg <= res_reg[3][C-1:0];
                    out_conf_reg   <= res_reg[4];
                    out_final_reg  <= (pending == '0);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign out_left       = out_left_reg;
    assign out_top        = out_top_reg;
    assign out_right      = out_right_reg;
    assign out_bottom     = out_bottom_reg;
    assign out_confidence = out_conf_reg;
    assign final_result   = out_final_reg;

endmodule

FILE: rtl/tnf_checker.sv
module tnf_checker #(
    parameter int COORD_BITS = tnf_pkg::COORD_BITS_DEFAULT
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [COORD_BITS-1:0]       out_left,
    input logic [COORD_BITS-1:0]       out_top,
    input logic [COORD_BITS-1:0]       out_right,
    input logic [COORD_BITS-1:0]       out_bottom,
    input logic [tnf_pkg::SCORE_W-1:0] out_confidence,
    input logic                        final_result
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before it was taken");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_left) && $stable(out_top) &&
            $stable(out_right) && $stable(out_bottom) &&
            $stable(out_confidence) && $stable(final_result))
        else $error("stalled result changed");

    // A result on offer always carries fully defined fields.
    a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !$isunknown({out_left, out_top, out_right, out_bottom,
                                   out_confidence, final_result}))
        else $error("result offered with undefined fields");

endmodule

bind topk_nms_box_filter tnf_checker #(.COORD_BITS(COORD_BITS)) u_tnf_checker (.*);

FILE: dv/tb_topk_nms_box_filter.sv
module tb_topk_nms_box_filter;

    localparam int NBOX = 64;
    localparam int WATCHDOG_LIMIT = 400000;

    typedef struct {
        logic [11:0] l;
        logic [11:0] t;
        logic [11:0] r;
        logic [11:0] b;
        logic [15:0] c;
        logic        fin;
    } box_t;

    class nms_scoreboard;
        logic [15:0] overlap_limit;
        logic        merge_mode;
        logic [6:0]  keep_count;
        box_t        stored[NBOX];
        int          loaded;
        box_t        kept_boxes[$];
        longint      exp_weight[256];
        int          errors;
        int          results_seen;
        int          sets_done;

        function new();
            longint x, term, sum;
            overlap_limit = tnf_pkg::OVERLAP_LIMIT_RESET;
            merge_mode = 1'b0;
            keep_count = tnf_pkg::KEEP_COUNT_RESET;
            loaded = 0;
            errors = 0;
            results_seen = 0;
            sets_done = 0;
            // Weight table: exp(i/256) by a series through the twelfth power in Q30, rounded to Q2.14.
            for (int i = 0; i < 256; i++)
            begin
                x = longint'(i) << 22;
                term = 64'd1 << 30;
                sum = term;
                for (int k = 1; k <= 12; k++)
                begin
                    term = ((term * x) >> 30) / k;
                    sum += term;
                end
                exp_weight[i] = (sum + (64'd1 << 15)) >> 16;
            end
        endfunction

        function longint area(box_t a);
            return (longint'(a.r) - longint'(a.l) + 1) * (longint'(a.b) - longint'(a.t) + 1);
        endfunction

        function bit merges(box_t a, box_t o);
            longint x0, y0, x1, y1, iw, ih, inter, uni;
            x0 = (a.l > o.l) ? a.l : o.l;
            y0 = (a.t > o.t) ? a.t : o.t;
            x1 = (a.r < o.r) ? a.r : o.r;
            y1 = (a.b < o.b) ? a.b : o.b;
            iw = x1 - x0 + 1;
            ih = y1 - y0 + 1;
            if (iw <= 0 || ih <= 0)
                return 1'b0;
            inter = iw * ih;
            uni = area(a) + area(o) - inter;
            if (uni <= 0)
                return 1'b0;
            return (inter * 65536) > (longint'(overlap_limit) * uni);
        endfunction

        function void note_box(box_t bx);
            int rank[NBOX];
            bit absorbed[NBOX];
            int n, kept, j, first_new;
            longint wsum, w, acc[5];
            box_t ld, ot, res;
            if (loaded < NBOX)
            begin
                stored[loaded] = bx;
                loaded++;
            end
            if (!bx.fin)
                return;
            n = loaded;
            for (int i = 0; i < n; i++)
            begin
                j = i;
                while (j > 0 && stored[rank[j-1]].c < stored[i].c)
                begin
                    rank[j] = rank[j-1];
                    j--;
                end
                rank[j] = i;
            end
            kept = (keep_count < n) ? keep_count : n;
            for (int i = 0; i < NBOX; i++)
                absorbed[i] = 1'b0;
            first_new = kept_boxes.size();
            for (int i = 0; i < kept; i++)
            begin
                if (absorbed[i])
                    continue;
                absorbed[i] = 1'b1;
                ld = stored[rank[i]];
                wsum = exp_weight[ld.c >> 8];
                acc[0] = wsum * ld.l;
                acc[1] = wsum * ld.t;
                acc[2] = wsum * ld.r;
                acc[3] = wsum * ld.b;
                acc[4] = wsum * ld.c;
                for (int k = i + 1; k < kept; k++)
                begin
                    ot = stored[rank[k]];
                    if (absorbed[k] || !merges(ld, ot))
                        continue;
                    absorbed[k] = 1'b1;
                    w = exp_weight[ot.c >> 8];
                    wsum += w;
                    acc[0] += w * ot.l;
                    acc[1] += w * ot.t;
                    acc[2] += w * ot.r;
                    acc[3] += w * ot.b;
                    acc[4] += w * ot.c;
                end
                if (!merge_mode)
                    res = ld;
                else
                begin
                    res.l = 12'((acc[0] + wsum / 2) / wsum);
                    res.t = 12'((acc[1] + wsum / 2) / wsum);
                    res.r = 12'((acc[2] + wsum / 2) / wsum);
                    res.b = 12'((acc[3] + wsum / 2) / wsum);
                    res.c = 16'((acc[4] + wsum / 2) / wsum);
                end
                res.fin = 1'b0;
                kept_boxes.insert(kept_boxes.size(), res);
            end
            if (kept_boxes.size() > first_new)
                kept_boxes[kept_boxes.size()-1].fin = 1'b1;
            loaded = 0;
            sets_done++;
        endfunction

        function void check_result(box_t got);
            box_t exp_box;
            results_seen++;
            if (kept_boxes.size() == 0)
            begin
                $error("result with no box expected");
                errors++;
                return;
            end
            exp_box = kept_boxes.pop_front();
            if (got.l !== exp_box.l)
            begin
                $error("out_left expected %0d got %0d", exp_box.l, got.l);
                errors++;
            end
            if (got.t !== exp_box.t)
            begin
                $error("out_top expected %0d got %0d", exp_box.t, got.t);
                errors++;
            end
            if (got.r !== exp_box.r)
            begin
                $error("out_right expected %0d got %0d", exp_box.r, got.r);
                errors++;
            end
            if (got.b !== exp_box.b)
            begin
                $error("out_bottom expected %0d got %0d", exp_box.b, got.b);
                errors++;
            end
            if (got.c !== exp_box.c)
            begin
                $error("out_confidence expected %0d got %0d", exp_box.c, got.c);
                errors++;
            end
            if (got.fin !== exp_box.fin)
            begin
                $error("final_result expected %0d got %0d", exp_box.fin, got.fin);
                errors++;
            end
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_write;
    logic [tnf_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [tnf_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                           in_valid;
    logic                           in_ready;
    logic [11:0]                    left_edge;
    logic [11:0]                    top_edge;
    logic [11:0]                    right_edge;
    logic [11:0]                    bottom_edge;
    logic [15:0]                    confidence;
    logic                           final_box;
    logic                           out_valid;
    logic                           out_ready;
    logic [11:0]                    out_left;
    logic [11:0]                    out_top;
    logic [11:0]                    out_right;
    logic [11:0]                    out_bottom;
    logic [15:0]                    out_confidence;
    logic                           final_result;

    nms_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;
    int items_sent = 0;
    int quiet_cycles = 0;

    topk_nms_box_filter dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .left_edge(left_edge), .top_edge(top_edge), .right_edge(right_edge),
        .bottom_edge(bottom_edge), .confidence(confidence), .final_box(final_box),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_left(out_left), .out_top(out_top), .out_right(out_right),
        .out_bottom(out_bottom), .out_confidence(out_confidence),
        .final_result(final_result)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Result side: random stalls, plus a long hold-off when one is requested.
    always @(posedge clk)
    begin
        box_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.l = out_left;
            got.t = out_top;
            got.r = out_right;
            got.b = out_bottom;
            got.c = out_confidence;
            got.fin = final_result;
            sb.check_result(got);
        end
        if (hold_cycles > 0)
        begin
            out_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout with %0d boxes still expected", sb.kept_boxes.size());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic send_box(input box_t bx);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        left_edge <= bx.l;
        top_edge <= bx.t;
        right_edge <= bx.r;
        bottom_edge <= bx.b;
        confidence <= bx.c;
        final_box <= bx.fin;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_box(bx);
        items_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.kept_boxes.size() > 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_reg(input logic [tnf_pkg::CFG_IDX_W-1:0] idx, input int value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[tnf_pkg::CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == tnf_pkg::REG_OVERLAP_LIMIT)
            sb.overlap_limit = value[15:0];
        else if (idx == tnf_pkg::REG_MERGE_MODE)
            sb.merge_mode = value[0];
        else if (idx == tnf_pkg::REG_KEEP_COUNT)
            sb.keep_count = value[6:0];
    endtask

    task automatic set_regs(input int limit, input int mode, input int keep);
        write_reg(tnf_pkg::REG_OVERLAP_LIMIT, limit);
        write_reg(tnf_pkg::REG_MERGE_MODE, mode);
        write_reg(tnf_pkg::REG_KEEP_COUNT, keep);
    endtask

    function automatic box_t make_box(input box_t anchor, input bit wild, input bit fin);
        box_t bx;
        int w, h;
        if (wild)
        begin
            bx.l = 12'($urandom);
            bx.t = 12'($urandom);
            bx.r = 12'($urandom);
            bx.b = 12'($urandom);
        end
        else
        begin
            // Jitter around the anchor so that many pairs overlap heavily.
            w = $urandom_range(40);
            h = $urandom_range(40);
            bx.l = 12'(int'(anchor.l) + int'($urandom_range(8)));
            bx.t = 12'(int'(anchor.t) + int'($urandom_range(8)));
            bx.r = (int'(bx.l) + w > 4095) ? 12'd4095 : 12'(int'(bx.l) + w);
            bx.b = (int'(bx.t) + h > 4095) ? 12'd4095 : 12'(int'(bx.t) + h);
        end
        bx.c = ($urandom_range(7) == 0) ? anchor.c : 16'($urandom);
        bx.fin = fin;
        return bx;
    endfunction

    // One set of n boxes drawn mostly around a few anchors; n above 64 overflows the store.
    task automatic random_set(input int n);
        box_t anchors[3];
        for (int a = 0; a < 3; a++)
        begin
            anchors[a].l = 12'($urandom_range(4040));
            anchors[a].t = 12'($urandom_range(4040));
            anchors[a].c = 16'($urandom);
        end
        for (int i = 0; i < n; i++)
            send_box(make_box(anchors[$urandom_range(2)], $urandom_range(3) == 0, i == n - 1));
    endtask

    task automatic random_phase(input int budget);
        int start;
        start = items_sent;
        while (items_sent - start < budget)
            random_set($urandom_range(1, 8));
    endtask

    task automatic directed_part();
        box_t bx;
        // Full-frame box and a tiny corner box: both survive at the default limit.
        bx = '{12'd0, 12'd0, 12'd4095, 12'd4095, 16'hFFFF, 1'b0};
        send_box(bx);
        bx = '{12'd4095, 12'd4095, 12'd4095, 12'd4095, 16'h0000, 1'b0};
        send_box(bx);
        // Degenerate box that can only lead its own cluster.
        bx = '{12'd100, 12'd100, 12'd50, 12'd50, 16'h8000, 1'b0};
        send_box(bx);
        // Two identical boxes with equal scores: the earlier one leads.
        bx = '{12'd10, 12'd10, 12'd20, 12'd20, 16'h4000, 1'b0};
        send_box(bx);
        bx.fin = 1'b1;
        send_box(bx);
        // A single-box set.
        bx = '{12'd7, 12'd9, 12'd300, 12'd400, 16'h1234, 1'b1};
        send_box(bx);
        drain();
        set_regs(0, 1, 64);
        for (int i = 0; i < 4; i++)
        begin
            bx = '{12'(200 + i), 12'(200), 12'(260 + i), 12'(270), 16'(16'hF000 - i * 4096), i == 3};
            send_box(bx);
        end
        drain();
        set_regs(65535, 0, 1);
        for (int i = 0; i < 4; i++)
        begin
            bx = '{12'(i), 12'(i), 12'(i + 5), 12'(i + 5), 16'(i * 100), i == 3};
            send_box(bx);
        end
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        left_edge = '0;
        top_edge = '0;
        right_edge = '0;
        bottom_edge = '0;
        confidence = '0;
        final_box = 1'b0;
        out_ready = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_part();

        set_regs(19661, 1, 64);
        random_phase(45);
        drain();

        send_idle_pct = 66;
        set_regs(65535, 0, 3);
        random_phase(40);
        drain();

        send_idle_pct = 0;
        recv_stall_pct = 66;
        set_regs($urandom_range(1, 65534), 1, 5);
        random_phase(40);
        drain();

        // Overfull set: the last two boxes are dropped, the final flag still counts.
        send_idle_pct = 7;
        recv_stall_pct = 7;
        set_regs(30000, 1, 100);
        random_set(66);
        random_phase(25);
        drain();

        // Hold the result side off while boxes keep coming, so the input backs up.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        set_regs(8000, 0, 64);
        hold_cycles = 6000;
        random_phase(30);
        drain();

        set_regs(0, 0, 1);
        random_phase(15);
        drain();

        $display("sent %0d boxes in %0d sets, checked %0d results", items_sent, sb.sets_done,
                 sb.results_seen);
        $display("covered hard and blended merging, keep limits from 1 to above the store size");
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
